/* rtl/bba_pkg.sv */
package bba_pkg;

  // fixed field widths
  localparam int BLK_W  = 10;
  localparam int STAT_W = 2;
  localparam int CFG_W  = 11;

  // highest block count that granted_block can name
  localparam int GRANT_SPAN = 1024;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_ROOT = 2'd2;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_SCAN = 6'b000100,
    S_FDIV = 6'b001000,
    S_FRD  = 6'b010000,
    S_FWR  = 6'b100000
  } state_t;

endpackage

/* rtl/block_bitmap_allocator_top.sv */
// first-fit block allocator over a used/free bitmap held in one synchronous ram
// command channel: a transaction is taken at a clock edge with start high and busy
// low. kind 0 allocates the lowest free block below the configured limit, kind 1
// frees block_number. every transaction returns exactly one result on
// granted_block/status, shown for one cycle with done high. the receiver has no
// way to hold a result off, and none is needed: the result sits in output
// registers and busy is already low in the done cycle, so the next start can be
// taken in the same cycle that a result is shown.
// what each transaction does, start edge to done cycle:
//   allocate: reads the bitmap words in order from word 0 and grants in the first
//     word with a free bit under the limit. one ram read per cycle sets the pace,
//     and a full map answers after the last word under the limit
//   free: word index by reciprocal multiply, ram read, write back
//   free of the root or beyond the map, allocate with zero limit: answered in idle
// configuration: blocks_in_use is written over its own valid/ready channel,
// always ready, and is saturated on write to the map size or GRANT_SPAN,
// whichever is smaller. write it only while the block is idle.
// reset (rst, synchronous): a clearing pass zeroes the bitmap one word per cycle,
// all NUM_BLOCKS/WORD_BITS (rounded up) words, with busy high throughout
module block_bitmap_allocator_top #(
  parameter int NUM_BLOCKS = 1024,
  parameter int WORD_BITS  = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         kind,
  input  logic [bba_pkg::BLK_W-1:0]    block_number,
  // result channel
  output logic                         done,
  output logic [bba_pkg::BLK_W-1:0]    granted_block,
  output logic [bba_pkg::STAT_W-1:0]   status,
  // configuration channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bba_pkg::CFG_W-1:0]    blocks_in_use
);

  import bba_pkg::*;

  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  // block base of a scanned word stays below limit + WORD_BITS
  localparam int BASE_W    = $clog2(GRANT_SPAN + WORD_BITS + 1);
  // largest usable limit
  localparam int CAP       = (NUM_BLOCKS < GRANT_SPAN) ? NUM_BLOCKS : GRANT_SPAN;
  // word index = (blk * RECIP) >> SHIFT, exact for any 10 bit block number
  localparam int SHIFT     = 20;
  localparam int RECIP     = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int PROD_W    = BLK_W + 18;
  localparam int MUL_W     = 16;

  // bitmap ram, registered read
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata;
  logic [AW-1:0]        mem_ra;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata <= mem[mem_ra];
  end

  state_t               state;
  logic [CFG_W-1:0]     limit;      // saturated blocks_in_use
  logic [AW-1:0]        clr_addr;   // clearing pass pointer
  logic [AW-1:0]        chk_addr;   // word whose data is in rdata during scan
  logic [BASE_W-1:0]    chk_base;   // first block number of that word
  logic [BLK_W-1:0]     op_blk;     // block being freed
  logic [BLK_W-1:0]     q;          // its word index
  logic [BIT_W-1:0]     bit_idx;    // its bit inside the word

  // scan datapath
  logic [BASE_W-1:0]    rem;
  logic [BASE_W-1:0]    next_base;
  logic [WORD_BITS-1:0] free_vec;
  logic                 found;
  logic [BIT_W-1:0]     found_idx;
  logic [PROD_W-1:0]    prod;
  logic [MUL_W-1:0]     q_times_w;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  assign rem       = BASE_W'(limit) - chk_base;
  assign next_base = chk_base + BASE_W'(WORD_BITS);
  assign prod      = PROD_W'(op_blk) * PROD_W'(RECIP);
  assign q_times_w = MUL_W'(q) * MUL_W'(WORD_BITS);

  // free bits of the current word that lie below the limit, lowest first
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      free_vec[i] = ~rdata[i] & (BASE_W'(i) < rem);
    end
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        found     = 1'b1;
        found_idx = BIT_W'(i);
      end
    end
  end

  // ram port control
  always_comb begin
    mem_ra = '0;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    case (state)
      S_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
      end
      S_SCAN: begin
        // prefetch the next word, dropped if this one grants
        mem_ra = chk_addr + AW'(1);
        if (found) begin
          mem_we = 1'b1;
          mem_wa = chk_addr;
          mem_wd = rdata | (WORD_BITS'(1) << found_idx);
        end
      end
      S_FRD: begin
        mem_ra = AW'(q);
      end
      S_FWR: begin
        mem_we = 1'b1;
        mem_wa = AW'(q);
        mem_wd = rdata & ~(WORD_BITS'(1) << bit_idx);
      end
      default: begin
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= CFG_W'(CAP);
    end else if (cfg_valid && cfg_ready) begin
      limit <= (blocks_in_use > CFG_W'(CAP)) ? CFG_W'(CAP) : blocks_in_use;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(MAP_WORDS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (kind == KIND_ALLOC) begin
              if (limit == '0) begin
                done          <= 1'b1;
                granted_block <= '0;
                status        <= ST_FULL;
              end else begin
                // word 0 read is issued this cycle
                chk_addr <= '0;
                chk_base <= '0;
                state    <= S_SCAN;
              end
            end else if (block_number == '0) begin
              done          <= 1'b1;
              granted_block <= '0;
              status        <= ST_ROOT;
            end else if (int'(block_number) >= NUM_BLOCKS) begin
              done          <= 1'b1;
              granted_block <= '0;
              status        <= ST_OK;
            end else begin
              op_blk <= block_number;
              state  <= S_FDIV;
            end
          end
        end
        S_SCAN: begin
          if (found) begin
            done          <= 1'b1;
            granted_block <= BLK_W'(chk_base + BASE_W'(found_idx));
            status        <= ST_OK;
            state         <= S_IDLE;
          end else if (next_base >= BASE_W'(limit)) begin
            done          <= 1'b1;
            granted_block <= '0;
            status        <= ST_FULL;
            state         <= S_IDLE;
          end else begin
            chk_addr <= chk_addr + AW'(1);
            chk_base <= next_base;
          end
        end
        S_FDIV: begin
          q     <= BLK_W'(prod >> SHIFT);
          state <= S_FRD;
        end
        S_FRD: begin
          bit_idx <= BIT_W'(op_blk - BLK_W'(q_times_w));
          state   <= S_FWR;
        end
        S_FWR: begin
          done          <= 1'b1;
          granted_block <= '0;
          status        <= ST_OK;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/block_bitmap_allocator_top_test.sv */
module block_bitmap_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bba_pkg::*;

  localparam int NUM_BLOCKS  = 1024;
  localparam int WORD_BITS   = 32;
  localparam int CLK_HALF    = 4;
  localparam int RESET_LEN   = 5;
  // worst correct pause with no transaction: clearing pass, full scan, sender gap
  // and a configuration switch; taken many times over
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_LEN  = 40;
  localparam int PRINT_CAP   = 100;

  // one command transaction as queued for the driver
  typedef struct packed {
    logic             kind;
    logic [BLK_W-1:0] blk;
  } block_request_t;

  // one result transaction as the allocator should show it
  typedef struct packed {
    logic [BLK_W-1:0]  grant;
    logic [STAT_W-1:0] stat;
  } alloc_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              kind = KIND_ALLOC;
  logic [BLK_W-1:0]  block_number = '0;
  logic              cfg_valid = 1'b0;
  logic [CFG_W-1:0]  blocks_in_use = '0;
  logic              busy;
  logic              done;
  logic [BLK_W-1:0]  granted_block;
  logic [STAT_W-1:0] status;
  logic              cfg_ready;

  // requests waiting to be driven, results waiting to be seen
  block_request_t request_q[$];
  alloc_result_t  pending_results[$];

  // shadow of the allocator: bitmap and configured block count
  logic [NUM_BLOCKS-1:0] block_used = '0;
  logic [CFG_W-1:0]      limit_cfg = 11'd1024;

  int mismatch_count = 0;
  int gap_pct = 0;
  int gap_left = 0;
  int stall_cycles = 0;

  block_bitmap_allocator_top #(
    .NUM_BLOCKS(NUM_BLOCKS),
    .WORD_BITS (WORD_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .kind         (kind),
    .block_number (block_number),
    .done         (done),
    .granted_block(granted_block),
    .status       (status),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .blocks_in_use(blocks_in_use)
  );

  always #(CLK_HALF) clk = ~clk;

  // first-fit allocation and free on the shadow bitmap
  function automatic alloc_result_t apply_request(logic k, logic [BLK_W-1:0] blk);
    alloc_result_t r;
    int            lim;
    r.grant = '0;
    r.stat  = ST_OK;
    if (k == KIND_ALLOC) begin
      // a count above the map or the grant range saturates
      lim = int'(limit_cfg);
      if (lim > NUM_BLOCKS) lim = NUM_BLOCKS;
      if (lim > GRANT_SPAN) lim = GRANT_SPAN;
      r.stat = ST_FULL;
      for (int b = 0; b < lim; b++) begin
        if (!block_used[b]) begin
          block_used[b] = 1'b1;
          r.grant = BLK_W'(b);
          r.stat  = ST_OK;
          break;
        end
      end
    end else if (blk == '0) begin
      // root is never released
      r.stat = ST_ROOT;
    end else if (int'(blk) < NUM_BLOCKS) begin
      // cleared even above the configured count
      block_used[blk] = 1'b0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("%0t mismatch: %s", $realtime, what);
  endtask

  // driver: one command transaction at a time, random gaps between them
  always @(posedge clk) begin
    block_request_t req;
    if (rst) begin
      start <= 1'b0;
    end else begin
      // transaction taken at this edge: predict it now, under the current count
      if (start && !busy) pending_results.push_back(apply_request(kind, block_number));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (request_q.size() != 0) begin
          req = request_q.pop_front();
          start <= 1'b1;
          kind <= req.kind;
          block_number <= req.blk;
          // random gap, with gap_pct percent chance, once this one is taken
          if (gap_pct != 0 && $urandom_range(99) < gap_pct) gap_left <= $urandom_range(1, 5);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done cycle is a result transaction, checked against the oldest one due
  always @(posedge clk) begin
    alloc_result_t due;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with none pending: block %0d status %0d",
                                granted_block, status));
      end else begin
        due = pending_results.pop_front();
        if (granted_block !== due.grant)
          flag_mismatch($sformatf("granted_block %0d, expected %0d", granted_block, due.grant));
        if (status !== due.stat)
          flag_mismatch($sformatf("status %0d, expected %0d", status, due.stat));
      end
    end
  end

  // watchdog: cycles in a row with no transaction on any channel
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("block_bitmap_allocator_top_test: FAIL");
        $finish;
      end
    end
  end

  task automatic push_request(logic k, int blk);
    block_request_t req;
    req.kind = k;
    req.blk  = BLK_W'(blk);
    request_q.push_back(req);
  endtask

  // random mix; most frees land in the low part where first fit packs the grants
  task automatic queue_random_requests(int n, int alloc_pct, int span);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < alloc_pct) push_request(KIND_ALLOC, $urandom_range(1023));
      else if ($urandom_range(99) < 3) push_request(KIND_FREE, 0);
      else if ($urandom_range(3) != 0) push_request(KIND_FREE, $urandom_range(span));
      else push_request(KIND_FREE, $urandom_range(1023));
    end
  endtask

  // sender holds off until every queued transaction has its result and the block is idle
  task automatic wait_drained();
    do @(negedge clk);
    while (request_q.size() != 0 || start || busy || pending_results.size() != 0);
  endtask

  // configuration transaction, only ever issued while idle
  task automatic write_block_limit(int value);
    wait_drained();
    @(posedge clk);
    cfg_valid <= 1'b1;
    blocks_in_use <= CFG_W'(value);
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    limit_cfg = blocks_in_use;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(int cfg, int n, int alloc_pct, int span, int gaps);
    write_block_limit(cfg);
    gap_pct = gaps;
    queue_random_requests(n, alloc_pct, span);
  endtask

  initial begin
    repeat (RESET_LEN) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset count of 1024, grants from the bottom, root refusal
    gap_pct = 20;
    push_request(KIND_ALLOC, 1023);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_ALLOC, 682);
    push_request(KIND_FREE, 0);
    push_request(KIND_FREE, 1);
    push_request(KIND_ALLOC, 0);
    // free of a block never granted, alternating bit patterns
    push_request(KIND_FREE, 1023);
    push_request(KIND_FREE, 682);
    push_request(KIND_FREE, 341);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_FREE, 2);
    push_request(KIND_ALLOC, 0);

    // zero count: nothing can be granted
    write_block_limit(0);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_FREE, 0);
    push_request(KIND_FREE, 3);
    push_request(KIND_ALLOC, 1023);

    // top of the register saturates to the map size
    write_block_limit(2047);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_ALLOC, 0);

    // count of one with the root taken; free above the count still clears
    write_block_limit(1);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_FREE, 700);

    // small count filled up to the full answer
    write_block_limit(6);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_ALLOC, 0);
    push_request(KIND_FREE, 5);

    write_block_limit(1025);
    push_request(KIND_ALLOC, 0);

    // random part: fill deep, churn at small counts, a stretch with no gaps
    run_phase(1024, 300, 92, 320, 25);
    run_phase(8, 60, 60, 12, 30);
    run_phase(2047, 120, 50, 1023, 0);
    run_phase(0, 20, 70, 1023, 20);
    run_phase(1, 20, 50, 4, 20);
    for (int p = 0; p < 3; p++) run_phase($urandom_range(2, 1024), 40, 60, 400, 20);
    // last part: no gaps, allocations until the whole map is in use
    run_phase(1024, 750, 100, 1023, 0);

    wait_drained();
    repeat (SETTLE_LEN) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("block_bitmap_allocator_top_test: PASS");
    end else begin
      $display("block_bitmap_allocator_top_test: FAIL");
    end
    $finish;
  end

endmodule

/* block_bitmap_allocator_top.f */
rtl/bba_pkg.sv
rtl/block_bitmap_allocator_top.sv
tb/block_bitmap_allocator_top_test.sv
